// ===== sv/mdsd_pkg.sv =====
// Package: shared types, codes and defaults for the mouse driver state device.
`default_nettype none
package mdsd_pkg;

  // Queue depths between the front, the back and the result port
  localparam int CMD_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF = 2;

  // Configuration reset values
  localparam logic [9:0]  X_SCALE_RST     = 10'd1;
  localparam logic [15:0] HORIZ_RATIO_RST = 16'd8;
  localparam logic [15:0] VERT_RATIO_RST  = 16'd16;

  // Fixed answers of the reset call
  localparam logic [15:0] RESET_INSTALLED = 16'hFFFF;
  localparam logic [15:0] RESET_BUTTONS   = 16'd3;

  // Button bit positions
  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;

  typedef enum logic [2:0] {
    CFG_X_SCALE     = 3'd0,
    CFG_HORIZ_RATIO = 3'd1,
    CFG_VERT_RATIO  = 3'd2,
    CFG_CALL_MASK   = 3'd3,
    CFG_CB_PRESENT  = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    OP_EVENT  = 3'd0,
    OP_RESET  = 3'd1,
    OP_STATUS = 3'd2,
    OP_PRESS  = 3'd3,
    OP_MOTION = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    EV_MOVE        = 3'd0,
    EV_LEFT_DOWN   = 3'd1,
    EV_LEFT_UP     = 3'd2,
    EV_RIGHT_DOWN  = 3'd3,
    EV_RIGHT_UP    = 3'd4,
    EV_MIDDLE_DOWN = 3'd5,
    EV_MIDDLE_UP   = 3'd6,
    EV_OTHER       = 3'd7
  } ev_t;

  // Classified command handed from the front to the back
  typedef enum logic [2:0] {
    CMD_EVENT,
    CMD_RESET,
    CMD_STATUS,
    CMD_PRESS,
    CMD_MOTION,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  event_kind;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic        which_button;
  } in_item_t;

  typedef struct packed {
    logic [15:0] reg_a;
    logic [15:0] reg_b;
    logic [15:0] reg_c;
    logic [15:0] reg_d;
    logic        callback_fire;
    logic [6:0]  callback_events;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  x_scale;
    logic [15:0] horiz_ratio;
    logic [15:0] vert_ratio;
    logic [6:0]  call_mask;
    logic        callback_present;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    ev_t         ev;
    logic [15:0] x;
    logic [15:0] y;
    logic        btn;
    logic        fire;
    logic [6:0]  hit;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/mdsd_fifo.sv =====
// Small register queue used between the front, the back and the result port.
`default_nettype none
module mdsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/mdsd_front.sv =====
// Front: decode an incoming item, scale x and work out the callback mask.
`default_nettype none
module mdsd_front import mdsd_pkg::*; (
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output cmd_t          cmd
);

  logic [9:0]  sx;
  logic [25:0] x_prod;
  logic [6:0]  ev_mask;
  logic [6:0]  hit;

  // Treat a zero scale as one, then scale the host x
  assign sx     = (cfg.x_scale == '0) ? 10'd1 : cfg.x_scale;
  assign x_prod = item.event_x * sx;

  // One mask bit per event class; other events have none
  assign ev_mask = (ev_t'(item.event_kind) == EV_OTHER) ? 7'd0
                 : (7'd1 << item.event_kind);
  assign hit     = ev_mask & cfg.call_mask;

  // Classify the item
  always_comb begin
    cmd.ev   = ev_t'(item.event_kind);
    cmd.x    = x_prod[15:0];
    cmd.y    = item.event_y;
    cmd.btn  = item.which_button;
    cmd.hit  = '0;
    cmd.fire = 1'b0;
    unique case (op_t'(item.opcode))
      OP_EVENT: begin
        cmd.kind = CMD_EVENT;
        cmd.hit  = hit;
        cmd.fire = (hit != '0) && cfg.callback_present;
      end
      OP_RESET:  cmd.kind = CMD_RESET;
      OP_STATUS: cmd.kind = CMD_STATUS;
      OP_PRESS:  cmd.kind = CMD_PRESS;
      OP_MOTION: cmd.kind = CMD_MOTION;
      default:   cmd.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/mdsd_back.sv =====
// Back: hold the mouse state, carry out one command a cycle when not stalled, build the result.
`default_nettype none
module mdsd_back import mdsd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  input  wire cmd_t cmd,
  input  wire logic res_full,
  output logic      res_push,
  output out_item_t res
);

  logic [15:0] pos_x, pos_x_next;
  logic [15:0] pos_y, pos_y_next;
  logic [2:0]  button_bits, button_bits_next;
  logic [15:0] left_presses, left_presses_next;
  logic [15:0] right_presses, right_presses_next;
  logic [31:0] left_press_pos, left_press_pos_next;
  logic [31:0] right_press_pos, right_press_pos_next;
  logic [31:0] prev_motion_pos, prev_motion_pos_next;

  logic        go;
  logic [15:0] dx;
  logic [15:0] dy;
  logic [28:0] mx;
  logic [28:0] my;
  logic [2:0]  bits_ev;

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  // Motion since the last motion read, scaled by ratio/8
  assign dx = pos_x - prev_motion_pos[15:0];
  assign dy = pos_y - prev_motion_pos[31:16];
  assign mx = dx * cfg.horiz_ratio[15:3];
  assign my = dy * cfg.vert_ratio[15:3];

  // Button bits after an event
  always_comb begin
    bits_ev = button_bits;
    unique case (cmd.ev)
      EV_LEFT_DOWN:   bits_ev[BTN_LEFT]   = 1'b1;
      EV_LEFT_UP:     bits_ev[BTN_LEFT]   = 1'b0;
      EV_RIGHT_DOWN:  bits_ev[BTN_RIGHT]  = 1'b1;
      EV_RIGHT_UP:    bits_ev[BTN_RIGHT]  = 1'b0;
      EV_MIDDLE_DOWN: bits_ev[BTN_MIDDLE] = 1'b1;
      EV_MIDDLE_UP:   bits_ev[BTN_MIDDLE] = 1'b0;
      default:        bits_ev = button_bits;
    endcase
  end

  // Next state and result for the command at the head of the queue
  always_comb begin
    pos_x_next           = pos_x;
    pos_y_next           = pos_y;
    button_bits_next     = button_bits;
    left_presses_next    = left_presses;
    right_presses_next   = right_presses;
    left_press_pos_next  = left_press_pos;
    right_press_pos_next = right_press_pos;
    prev_motion_pos_next = prev_motion_pos;
    res                  = '0;
    unique case (cmd.kind)
      CMD_EVENT: begin
        pos_x_next       = cmd.x;
        pos_y_next       = cmd.y;
        button_bits_next = bits_ev;
        if (cmd.ev == EV_LEFT_DOWN) begin
          left_press_pos_next = {cmd.y, cmd.x};
          left_presses_next   = left_presses + 16'd1;
        end
        if (cmd.ev == EV_RIGHT_DOWN) begin
          right_press_pos_next = {cmd.y, cmd.x};
          right_presses_next   = right_presses + 16'd1;
        end
        res.reg_b           = {13'd0, bits_ev};
        res.reg_c           = cmd.x;
        res.reg_d           = cmd.y;
        res.callback_fire   = cmd.fire;
        res.callback_events = cmd.hit;
      end
      CMD_RESET: begin
        pos_x_next           = '0;
        pos_y_next           = '0;
        button_bits_next     = '0;
        left_presses_next    = '0;
        right_presses_next   = '0;
        left_press_pos_next  = '0;
        right_press_pos_next = '0;
        prev_motion_pos_next = '0;
        res.reg_a            = RESET_INSTALLED;
        res.reg_b            = RESET_BUTTONS;
      end
      CMD_STATUS: begin
        res.reg_b = {13'd0, button_bits};
        res.reg_c = pos_x;
        res.reg_d = pos_y;
      end
      CMD_PRESS: begin
        res.reg_a = {13'd0, button_bits};
        if (cmd.btn) begin
          res.reg_b          = right_presses;
          res.reg_c          = right_press_pos[15:0];
          res.reg_d          = right_press_pos[31:16];
          right_presses_next = '0;
        end else begin
          res.reg_b         = left_presses;
          res.reg_c         = left_press_pos[15:0];
          res.reg_d         = left_press_pos[31:16];
          left_presses_next = '0;
        end
      end
      CMD_MOTION: begin
        res.reg_c            = mx[15:0];
        res.reg_d            = my[15:0];
        prev_motion_pos_next = {pos_y, pos_x};
      end
      default: res = '0;
    endcase
  end

  // Commit state when the command retires
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x           <= '0;
      pos_y           <= '0;
      button_bits     <= '0;
      left_presses    <= '0;
      right_presses   <= '0;
      left_press_pos  <= '0;
      right_press_pos <= '0;
      prev_motion_pos <= '0;
    end else if (go) begin
      pos_x           <= pos_x_next;
      pos_y           <= pos_y_next;
      button_bits     <= button_bits_next;
      left_presses    <= left_presses_next;
      right_presses   <= right_presses_next;
      left_press_pos  <= left_press_pos_next;
      right_press_pos <= right_press_pos_next;
      prev_motion_pos <= prev_motion_pos_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.kind == CMD_RESET) |=>
      (left_presses == '0 && right_presses == '0 && button_bits == '0))
    else $error("reset call left state behind");

  a_left_count: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.kind == CMD_EVENT && cmd.ev == EV_LEFT_DOWN) |=>
      (left_presses == $past(left_presses) + 16'd1))
    else $error("left press not counted");

  a_press_read_clears: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.kind == CMD_PRESS && !cmd.btn) |=> (left_presses == '0))
    else $error("left press count not cleared by read");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !go |=> ($stable(pos_x) && $stable(pos_y) && $stable(prev_motion_pos)))
    else $error("state changed without a command");

  a_fire_has_events: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.callback_fire) |-> (res.callback_events != '0))
    else $error("callback fired with empty event mask");
`endif

endmodule
`default_nettype wire

// ===== sv/mouse_driver_state_device.sv =====
// Top level: configuration registers, front, command queue, back, result queue.
`default_nettype none
// Mouse state device with a mouse-driver style call interface. Both sides look
// like queues: push an item while full is low, pop a result while empty is low.
// Every item (host event or driver call) gives exactly one result, in order.
// The block takes one item per cycle while full is low; the figure is set by
// the back's state update, which retires one command per cycle while the
// result queue has room. A result is registered in the result queue before
// it shows on the result ports. The input keeps taking items while results
// wait, until the command queue (CMD_DEPTH entries) and result queue
// (RES_DEPTH entries) are both full.
// Configuration writes are always ready; write only while the block is idle.
// The reset call clears the mouse state but keeps the configuration.
module mouse_driver_state_device import mdsd_pkg::*; #(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    item,
  input  wire logic        pop,
  output logic             empty,
  output out_item_t        result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t      cfg;
  cmd_t      cmd_in;
  cmd_t      cmd_out;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale          <= X_SCALE_RST;
      cfg.horiz_ratio      <= HORIZ_RATIO_RST;
      cfg.vert_ratio       <= VERT_RATIO_RST;
      cfg.call_mask        <= '0;
      cfg.callback_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_X_SCALE:     cfg.x_scale          <= cfg_data[9:0];
        CFG_HORIZ_RATIO: cfg.horiz_ratio      <= cfg_data;
        CFG_VERT_RATIO:  cfg.vert_ratio       <= cfg_data;
        CFG_CALL_MASK:   cfg.call_mask        <= cfg_data[6:0];
        CFG_CB_PRESENT:  cfg.callback_present <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  mdsd_front u_front (
    .item (item),
    .cfg  (cfg),
    .cmd  (cmd_in)
  );

  mdsd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_out)
  );

  mdsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  mdsd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule
`default_nettype wire
